[hw/rtl/scd_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the face basis table for the spherified cube direction block.
package scd_pkg;

  localparam int RES_W  = 11;
  localparam int GRID_W = 11;
  localparam int FACE_W = 3;
  localparam int DIR_W  = 16;
  localparam int FRAC_W = 16;
  localparam int P_W    = FRAC_W + 2;

  localparam logic [RES_W-1:0] MAX_RES   = RES_W'(1024);
  localparam logic [RES_W-1:0] RES_RESET = RES_W'(16);

  localparam logic signed [P_W-1:0]   P_ONE       = P_W'(65536);
  localparam logic signed [DIR_W-1:0] DIR_MAX     = DIR_W'(32767);
  localparam logic signed [DIR_W-1:0] DIR_NEG_OUT = DIR_W'(16'h8000);

  localparam logic [FACE_W-1:0] FACE_PX = 3'd0;
  localparam logic [FACE_W-1:0] FACE_NX = 3'd1;
  localparam logic [FACE_W-1:0] FACE_PY = 3'd2;
  localparam logic [FACE_W-1:0] FACE_NY = 3'd3;
  localparam logic [FACE_W-1:0] FACE_PZ = 3'd4;
  localparam logic [FACE_W-1:0] FACE_NZ = 3'd5;

  typedef struct packed {
    logic [FACE_W-1:0] face;
    logic [GRID_W-1:0] grid_x;
    logic [GRID_W-1:0] grid_y;
  } in_t;

  typedef struct packed {
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
  } out_t;

  typedef struct packed {
    logic signed [P_W-1:0] x;
    logic signed [P_W-1:0] y;
    logic signed [P_W-1:0] z;
  } p_vec_t;

  // Faces six and seven share the +Z basis.
  function automatic p_vec_t face_point(input logic [FACE_W-1:0] face,
                                        input logic signed [P_W-1:0] u,
                                        input logic signed [P_W-1:0] v);
    p_vec_t p;
    case (face)
      FACE_PX: begin
        p.x = P_ONE;  p.y = v;  p.z = -u;
      end
      FACE_NX: begin
        p.x = -P_ONE; p.y = v;  p.z = u;
      end
      FACE_PY: begin
        p.x = u;  p.y = P_ONE;  p.z = -v;
      end
      FACE_NY: begin
        p.x = u;  p.y = -P_ONE; p.z = v;
      end
      FACE_NZ: begin
        p.x = -u; p.y = v;  p.z = -P_ONE;
      end
      FACE_PZ: begin
        p.x = u;  p.y = v;  p.z = P_ONE;
      end
      default: begin
        p.x = u;  p.y = v;  p.z = P_ONE;
      end
    endcase
    return p;
  endfunction

endpackage

[hw/rtl/scd_dly.sv]
`timescale 1ns / 1ps
// Enabled delay line that keeps side data aligned with the long arithmetic units.
module scd_dly #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] tap_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d_i;
      for (int k = 1; k < DEPTH; k++) begin
        tap_r[k] <= tap_r[k-1];
      end
    end
  end

  assign q_o = tap_r[DEPTH-1];

endmodule

[hw/rtl/scd_div.sv]
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage; the quotient must fit QW bits.
module scd_div #(
  parameter int NW = 27,
  parameter int DW = 11,
  parameter int QW = 17
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] low_r [QW];
  logic [QW-1:0] quo_r [QW];
  logic [DW-1:0] den_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] low_in;
    logic [QW-1:0] quo_in;
    logic [DW:0]   trial;
    logic          ge;
    logic [DW-1:0] rem_nxt;

    if (k == 0) begin : g_first
      assign rem_in = DW'(num_i >> QW);
      assign low_in = num_i[QW-1:0];
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign low_in = low_r[k-1];
      assign quo_in = quo_r[k-1];
      assign den_in = den_r[k-1];
    end

    assign trial   = {rem_in, low_in[QW-1]};
    assign ge      = trial >= {1'b0, den_in};
    assign rem_nxt = ge ? DW'(trial - {1'b0, den_in}) : DW'(trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        low_r[k] <= low_in << 1;
        quo_r[k] <= {quo_in[QW-2:0], ge};
        den_r[k] <= den_in;
      end
    end
  end

  assign quo_o = quo_r[QW-1];

endmodule

[hw/rtl/scd_sqrt.sv]
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per stage, floor result.
module scd_sqrt #(
  parameter int RW = 56
) (
  input  logic            clk,
  input  logic            en,
  input  logic [RW-1:0]   rad_i,
  output logic [RW/2-1:0] root_o
);

  localparam int QW = RW / 2;
  localparam int MW = QW + 1;

  logic [MW-1:0] rem_r  [QW];
  logic [QW-1:0] root_r [QW];
  logic [RW-1:0] rad_r  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [MW-1:0] rem_in;
    logic [QW-1:0] root_in;
    logic [RW-1:0] rad_in;
    logic [MW+1:0] t;
    logic [MW+1:0] trial;
    logic          ge;
    logic [MW-1:0] rem_nxt;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign rad_in  = rad_r[k-1];
    end

    assign t       = {rem_in, rad_in[RW-1 -: 2]};
    assign trial   = (MW+2)'({root_in, 2'b01});
    assign ge      = t >= trial;
    assign rem_nxt = ge ? MW'(t - trial) : MW'(t);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= {root_in[QW-2:0], ge};
        rad_r[k]  <= rad_in << 2;
      end
    end
  end

  assign root_o = root_r[QW-1];

endmodule

[hw/rtl/spherified_cube_direction.sv]
`timescale 1ns / 1ps
// Top level of the spherified cube direction pipeline.
//
//   channel  ports                            direction  payload
//   in       in_valid in_ready in_data        input      in_t: face, grid_x, grid_y
//   out      out_valid out_ready out_data     output     out_t: dir_x, dir_y, dir_z
//   cfg      cfg_valid cfg_ready cfg_data     input      grid_resolution, 11 bits
//
// One transaction is taken per cycle unless a result waits at the output; results leave in input order.
// The latency is set by two square root pipelines and two divider pipelines in series.
// Reset clears all valid bits and loads a grid resolution of 16.
// The whole pipeline holds while a result waits at the output, so nothing is lost.
module spherified_cube_direction
  import scd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_t             out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [RES_W-1:0] cfg_data
);

  localparam int K_W      = RES_W;
  localparam int UN_W     = K_W + FRAC_W;
  localparam int QUV_W    = FRAC_W + 1;
  localparam int PM_W     = FRAC_W + 1;
  localparam int A_W      = FRAC_W + 1;
  localparam int W_W      = 35;
  localparam int S_RW     = 56;
  localparam int S_W      = S_RW / 2;
  localparam int M_W      = 28;
  localparam int SQ_W     = 2 * M_W;
  localparam int SUM_W    = SQ_W + 2;
  localparam int L_W      = SUM_W / 2;
  localparam int DN_W     = M_W + 16;
  localparam int DQ_W     = 16;
  localparam int LAT_UV   = QUV_W;
  localparam int LAT_SW   = S_W;
  localparam int LAT_SL   = L_W;
  localparam int LAT_DD   = DQ_W;
  localparam int LAT      = 1 + LAT_UV + 4 + LAT_SW + 4 + LAT_SL + 1 + LAT_DD + 1;

  localparam logic [W_W:0] W_BASE = (W_W+1)'(6) << 32;

  logic             en;
  logic [LAT-1:0]   vld_r;
  logic [RES_W-1:0] res_r;
  logic [RES_W-1:0] res_nxt;

  assign en        = !vld_r[LAT-1] || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;
  assign out_valid = vld_r[LAT-1];

  always_comb begin
    if (cfg_data == '0) begin
      res_nxt = RES_W'(1);
    end else if (cfg_data > MAX_RES) begin
      res_nxt = MAX_RES;
    end else begin
      res_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      res_r <= RES_RESET;
    end else begin
      if (en) begin
        vld_r <= {vld_r[LAT-2:0], in_valid};
      end
      if (cfg_valid && cfg_ready) begin
        res_r <= res_nxt;
      end
    end
  end

  // Face coordinates: magnitude and sign of 2*g - R.
  logic [GRID_W-1:0] gx, gy;
  logic [GRID_W:0]   twox, twoy, resx;
  logic              su_nxt, sv_nxt;
  logic [GRID_W:0]   dx, dy;
  logic [K_W-1:0]    ku1_r, kv1_r;
  logic              su1_r, sv1_r;
  logic [FACE_W-1:0] face1_r;
  logic [RES_W-1:0]  res1_r;

  assign gx     = (in_data.grid_x > res_r) ? res_r : in_data.grid_x;
  assign gy     = (in_data.grid_y > res_r) ? res_r : in_data.grid_y;
  assign twox   = {gx, 1'b0};
  assign twoy   = {gy, 1'b0};
  assign resx   = {1'b0, res_r};
  assign su_nxt = twox < resx;
  assign sv_nxt = twoy < resx;
  assign dx     = su_nxt ? resx - twox : twox - resx;
  assign dy     = sv_nxt ? resx - twoy : twoy - resx;

  always_ff @(posedge clk) begin
    if (en) begin
      ku1_r   <= dx[K_W-1:0];
      kv1_r   <= dy[K_W-1:0];
      su1_r   <= su_nxt;
      sv1_r   <= sv_nxt;
      face1_r <= in_data.face;
      res1_r  <= res_r;
    end
  end

  logic [UN_W-1:0]   num_u, num_v;
  logic [QUV_W-1:0]  qu, qv;
  logic [FACE_W+1:0] side18;

  assign num_u = {ku1_r, {FRAC_W{1'b0}}} + UN_W'(res1_r >> 1);
  assign num_v = {kv1_r, {FRAC_W{1'b0}}} + UN_W'(res1_r >> 1);

  scd_div #(.NW(UN_W), .DW(RES_W), .QW(QUV_W)) u_div_u (
    .clk(clk), .en(en), .num_i(num_u), .den_i(res1_r), .quo_o(qu)
  );
  scd_div #(.NW(UN_W), .DW(RES_W), .QW(QUV_W)) u_div_v (
    .clk(clk), .en(en), .num_i(num_v), .den_i(res1_r), .quo_o(qv)
  );
  scd_dly #(.W(FACE_W + 2), .DEPTH(LAT_UV)) u_dly_face (
    .clk(clk), .en(en), .d_i({face1_r, su1_r, sv1_r}), .q_o(side18)
  );

  // Cube point, kept as magnitude and sign per component.
  logic signed [P_W-1:0] u_s, v_s;
  p_vec_t                p_nxt;
  logic signed [P_W-1:0] p_arr [3];
  logic [PM_W-1:0]       pm19_r [3];
  logic                  ps19_r [3];

  assign u_s   = side18[1] ? -$signed({1'b0, qu}) : $signed({1'b0, qu});
  assign v_s   = side18[0] ? -$signed({1'b0, qv}) : $signed({1'b0, qv});
  assign p_nxt = face_point(side18[FACE_W+1:2], u_s, v_s);
  assign p_arr[0] = p_nxt.x;
  assign p_arr[1] = p_nxt.y;
  assign p_arr[2] = p_nxt.z;

  logic [A_W-1:0]   a20_r    [3];
  logic [A_W:0]     suma21_r [3];
  logic [2*A_W-1:0] prod21_r [3];
  logic [W_W-1:0]   w22_r    [3];
  logic [S_W-1:0]   s50      [3];
  logic [PM_W:0]    pside50  [3];
  logic [M_W-1:0]   m51_r    [3];
  logic             ps51_r   [3];
  logic [SQ_W-1:0]  sq52_r   [3];
  logic [M_W:0]     mside83  [3];
  logic [DN_W-1:0]  num84_r  [3];
  logic             ps100    [3];
  logic [DQ_W-1:0]  q100     [3];
  logic signed [DIR_W-1:0] dir_nxt [3];

  for (genvar i = 0; i < 3; i++) begin : g_comp
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;
    logic signed [P_W-1:0] pabs;
    logic [2*PM_W-1:0]     psq;
    logic [W_W:0]          w_nxt;
    logic [PM_W+S_W-1:0]   cprod;

    assign pabs = p_arr[i][P_W-1] ? -p_arr[i] : p_arr[i];
    assign psq  = pm19_r[i] * pm19_r[i];

    always_ff @(posedge clk) begin
      if (en) begin
        pm19_r[i] <= pabs[PM_W-1:0];
        ps19_r[i] <= p_arr[i][P_W-1];
        a20_r[i]  <= A_W'((psq + (2*PM_W)'(32768)) >> FRAC_W);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        suma21_r[i] <= {1'b0, a20_r[J]} + {1'b0, a20_r[K]};
        prod21_r[i] <= a20_r[J] * a20_r[K];
      end
    end

    assign w_nxt = W_BASE + (W_W+1)'({prod21_r[i], 1'b0})
                   - (W_W+1)'({suma21_r[i], {FRAC_W{1'b0}}})
                   - (W_W+1)'({suma21_r[i], {(FRAC_W+1){1'b0}}});

    always_ff @(posedge clk) begin
      if (en) begin
        w22_r[i] <= w_nxt[W_W-1:0];
      end
    end

    scd_sqrt #(.RW(S_RW)) u_sqrt_w (
      .clk(clk), .en(en), .rad_i({1'b0, w22_r[i], 20'b0}), .root_o(s50[i])
    );
    scd_dly #(.W(PM_W + 1), .DEPTH(3 + LAT_SW)) u_dly_p (
      .clk(clk), .en(en), .d_i({ps19_r[i], pm19_r[i]}), .q_o(pside50[i])
    );

    assign cprod = pside50[i][PM_W-1:0] * s50[i];

    always_ff @(posedge clk) begin
      if (en) begin
        m51_r[i]  <= cprod[FRAC_W +: M_W];
        ps51_r[i] <= pside50[i][PM_W];
        sq52_r[i] <= m51_r[i] * m51_r[i];
      end
    end

    scd_dly #(.W(M_W + 1), .DEPTH(3 + LAT_SL)) u_dly_m (
      .clk(clk), .en(en), .d_i({ps51_r[i], m51_r[i]}), .q_o(mside83[i])
    );
  end

  logic [SQ_W:0]    part53_r;
  logic [SQ_W-1:0]  sq53_r;
  logic [SUM_W-1:0] sum54_r;
  logic [L_W-1:0]   len83;
  logic [L_W-1:0]   den84_r;
  logic             ps84_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      part53_r <= {1'b0, sq52_r[0]} + {1'b0, sq52_r[1]};
      sq53_r   <= sq52_r[2];
      sum54_r  <= SUM_W'(part53_r) + SUM_W'(sq53_r);
    end
  end

  scd_sqrt #(.RW(SUM_W)) u_sqrt_len (
    .clk(clk), .en(en), .rad_i(sum54_r), .root_o(len83)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      den84_r <= (len83 == '0) ? L_W'(1) : len83;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_norm
    logic [DQ_W-1:0] qsat;

    always_ff @(posedge clk) begin
      if (en) begin
        num84_r[i] <= DN_W'({mside83[i][M_W-1:0], 15'b0}) + DN_W'(len83 >> 1);
        ps84_r[i]  <= mside83[i][M_W];
      end
    end

    scd_div #(.NW(DN_W), .DW(L_W), .QW(DQ_W)) u_div_d (
      .clk(clk), .en(en), .num_i(num84_r[i]), .den_i(den84_r), .quo_o(q100[i])
    );
    scd_dly #(.W(1), .DEPTH(LAT_DD)) u_dly_s (
      .clk(clk), .en(en), .d_i(ps84_r[i]), .q_o(ps100[i])
    );

    assign qsat = (q100[i] > DQ_W'(DIR_MAX)) ? DQ_W'(DIR_MAX) : q100[i];
    assign dir_nxt[i] = ps100[i] ? -$signed(qsat) : $signed(qsat);
  end

  out_t dir_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dir_r.dir_x <= dir_nxt[0];
      dir_r.dir_y <= dir_nxt[1];
      dir_r.dir_z <= dir_nxt[2];
    end
  end

  assign out_data = dir_r;

endmodule

[hw/rtl/scd_chk.sv]
`timescale 1ns / 1ps
// Port-level checker for the spherified cube direction block and its bind statement.
module scd_chk
  import scd_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Stalled output transaction changed or vanished.");

  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("Input accepted while the output is stalled.");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.dir_x != DIR_NEG_OUT && out_data.dir_y != DIR_NEG_OUT
                  && out_data.dir_z != DIR_NEG_OUT)
    else $error("Direction component outside the saturated range.");

  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("Output valid right after reset.");

endmodule

bind spherified_cube_direction scd_chk u_scd_chk (
  .clk(clk),
  .rst_n(rst_n),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data(out_data)
);

[verif/spherified_cube_direction_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the spherified cube direction block.
module spherified_cube_direction_tb;
  import scd_pkg::*;

  localparam logic [FACE_W-1:0] FACE_SPARE_A = 3'd6;
  localparam logic [FACE_W-1:0] FACE_SPARE_B = 3'd7;
  localparam int DRAIN_CYCLES = 150;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    in_t  item;
    bit   typed;
    out_t dir;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [RES_W-1:0] cfg_data = '0;

  out_t dir_expected[$];
  dir_row_t directed_rows[$];
  logic [RES_W-1:0] res_shadow = RES_RESET;
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;

  spherified_cube_direction dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned val);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > val) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (val >= root + bitv) begin
        val = val - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic longint round_div(input longint num, input longint den);
    longint unsigned mag;
    longint unsigned quo;
    mag = (num < 0) ? -num : num;
    quo = (mag + den / 2) / den;
    return (num < 0) ? -longint'(quo) : longint'(quo);
  endfunction

  function automatic out_t predict_direction(input in_t item, input logic [RES_W-1:0] res_reg);
    longint res, gx, gy, u, v, sj, sk, w, d;
    longint pt[3], sqr[3], cmp[3];
    longint unsigned s, m, sum, len;
    out_t r;
    res = res_reg;
    if (res < 1) res = 1;
    if (res > MAX_RES) res = MAX_RES;
    gx = (item.grid_x > res) ? res : item.grid_x;
    gy = (item.grid_y > res) ? res : item.grid_y;
    u = round_div((2 * gx - res) * 65536, res);
    v = round_div((2 * gy - res) * 65536, res);
    case (item.face)
      FACE_PX: begin pt[0] = 65536;  pt[1] = v;      pt[2] = -u;     end
      FACE_NX: begin pt[0] = -65536; pt[1] = v;      pt[2] = u;      end
      FACE_PY: begin pt[0] = u;      pt[1] = 65536;  pt[2] = -v;     end
      FACE_NY: begin pt[0] = u;      pt[1] = -65536; pt[2] = v;      end
      FACE_NZ: begin pt[0] = -u;     pt[1] = v;      pt[2] = -65536; end
      default: begin pt[0] = u;      pt[1] = v;      pt[2] = 65536;  end
    endcase
    for (int i = 0; i < 3; i++) sqr[i] = (pt[i] * pt[i] + 32768) / 65536;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      sj = sqr[(i + 1) % 3];
      sk = sqr[(i + 2) % 3];
      w = (longint'(6) << 32) - 196608 * (sj + sk) + 2 * sj * sk;
      if (w < 0) w = 0;
      s = int_sqrt(longint'(w) << 20);
      m = (pt[i] < 0) ? -pt[i] : pt[i];
      m = (m * s) >> 16;
      cmp[i] = (pt[i] < 0) ? -longint'(m) : longint'(m);
      sum = sum + m * m;
    end
    len = int_sqrt(sum);
    if (len == 0) len = 1;
    for (int i = 0; i < 3; i++) begin
      d = round_div(cmp[i] * 32768, len);
      if (d > 32767) d = 32767;
      if (d < -32767) d = -32767;
      if (i == 0) r.dir_x = d[15:0];
      else if (i == 1) r.dir_y = d[15:0];
      else r.dir_z = d[15:0];
    end
    return r;
  endfunction

  function automatic out_t make_dir(input int dx, input int dy, input int dz);
    out_t r;
    r.dir_x = dx[15:0];
    r.dir_y = dy[15:0];
    r.dir_z = dz[15:0];
    return r;
  endfunction

  task automatic add_row(input logic [FACE_W-1:0] face, input int gx, input int gy,
                         input bit typed, input out_t dir);
    dir_row_t row;
    row.item.face = face;
    row.item.grid_x = gx[GRID_W-1:0];
    row.item.grid_y = gy[GRID_W-1:0];
    row.typed = typed;
    row.dir = dir;
    directed_rows = {directed_rows, row};
  endtask

  task automatic send_item(input in_t item, input bit typed, input out_t dir);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = item;
    do @(posedge clk); while (!in_ready);
    dir_expected = {dir_expected, (typed ? dir : predict_direction(item, res_shadow))};
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    wait (dir_expected.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_resolution(input logic [RES_W-1:0] val);
    drain_results();
    cfg_valid = 1'b1;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    res_shadow = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic in_t random_item(input logic [RES_W-1:0] res_reg);
    int eff;
    in_t item;
    eff = (res_reg == 0) ? 1 : (res_reg > MAX_RES) ? MAX_RES : res_reg;
    item.face = FACE_W'($urandom_range(7));
    if ($urandom_range(9) == 0) begin
      item.grid_x = GRID_W'($urandom);
      item.grid_y = GRID_W'($urandom);
    end else begin
      item.grid_x = GRID_W'($urandom_range(eff));
      item.grid_y = GRID_W'($urandom_range(eff));
    end
    return item;
  endfunction

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (dir_expected.size() == 0) begin
        $error("Result transaction with no expectation waiting");
        errors++;
      end else begin
        want = dir_expected.pop_front();
        if (out_data.dir_x !== want.dir_x) begin
          $error("dir_x expected %0d actual %0d", want.dir_x, out_data.dir_x);
          errors++;
        end
        if (out_data.dir_y !== want.dir_y) begin
          $error("dir_y expected %0d actual %0d", want.dir_y, out_data.dir_y);
          errors++;
        end
        if (out_data.dir_z !== want.dir_z) begin
          $error("dir_z expected %0d actual %0d", want.dir_z, out_data.dir_z);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [RES_W-1:0] settings[8];
    out_t none;
    none = '0;
    settings = '{RES_W'(1), RES_W'(1024), RES_W'(0), RES_W'(2047), RES_W'(3),
                 RES_W'(7), RES_W'(255), RES_W'(16)};

    add_row(FACE_PX, 8, 8, 1'b1, make_dir(32767, 0, 0));
    add_row(FACE_NX, 8, 8, 1'b1, make_dir(-32767, 0, 0));
    add_row(FACE_PY, 8, 8, 1'b1, make_dir(0, 32767, 0));
    add_row(FACE_NY, 8, 8, 1'b1, make_dir(0, -32767, 0));
    add_row(FACE_PZ, 8, 8, 1'b1, make_dir(0, 0, 32767));
    add_row(FACE_NZ, 8, 8, 1'b1, make_dir(0, 0, -32767));
    add_row(FACE_SPARE_A, 8, 8, 1'b1, make_dir(0, 0, 32767));
    add_row(FACE_SPARE_B, 8, 8, 1'b1, make_dir(0, 0, 32767));
    add_row(FACE_PX, 0, 0, 1'b0, none);
    add_row(FACE_NX, 16, 16, 1'b0, none);
    add_row(FACE_PY, 0, 16, 1'b0, none);
    add_row(FACE_NY, 16, 0, 1'b0, none);
    add_row(FACE_PZ, 2047, 2047, 1'b0, none);
    add_row(FACE_NZ, 17, 5, 1'b0, none);
    add_row(FACE_SPARE_A, 0, 2047, 1'b0, none);
    add_row(FACE_SPARE_B, 1365, 682, 1'b0, none);
    add_row(FACE_PX, 1, 15, 1'b0, none);
    add_row(FACE_NX, 3, 12, 1'b0, none);
    add_row(FACE_PY, 1024, 1024, 1'b0, none);
    add_row(FACE_NY, 5, 11, 1'b0, none);

    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].dir);

    foreach (settings[s]) begin
      write_resolution(settings[s]);
      case (s % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      if (s == 0) hold_cycles = 600;
      for (int n = 0; n < 175; n++) send_item(random_item(res_shadow), 1'b0, none);
    end

    drain_results();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/scd_pkg.sv
hw/rtl/scd_dly.sv
hw/rtl/scd_div.sv
hw/rtl/scd_sqrt.sv
hw/rtl/spherified_cube_direction.sv
hw/rtl/scd_chk.sv
verif/spherified_cube_direction_tb.sv
